// ===== src/mfsk_pkg.sv =====
// Shared types, constants and register codes for the multitone FSK modulator.
`timescale 1ns / 1ps

package mfsk_pkg;

	localparam int SAMPLES_PER_SYMBOL_DEF = 32;
	localparam int PHASE_BITS_DEF         = 16;

	// clock tone, carrier tone, eight bit tones
	localparam int NUM_TONES = 10;
	localparam int TONE_CLK  = 0;
	localparam int TONE_CAR  = 1;
	localparam int TONE_BIT0 = 2;

	// sine unit latency from angle register to tone value register
	localparam int SINE_LAT = 5;

	localparam int SINE_W = 18;
	localparam int SUM_W  = 22;
	localparam int PROD_W = 36;

	localparam logic [14:0] SINE_QUARTER = 15'd16384;
	localparam logic [10:0] SINE_C1      = 11'd1160;
	localparam logic [13:0] SINE_C2      = 14'd10512;
	localparam logic [14:0] SINE_C3      = 15'd25736;

	localparam logic signed [13:0] SCALE_DATA = 14'sd1200;
	localparam logic signed [13:0] SCALE_PRE  = 14'sd4000;

	localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(32767);
	localparam logic signed [20:0]       SAT_MAX    = 21'sd32767;
	localparam logic signed [20:0]       SAT_MIN    = -21'sd32768;

	typedef enum logic [2:0] {
		REG_BIT_TONE_A,
		REG_BIT_TONE_B,
		REG_BIT_TONE_C,
		REG_BIT_TONE_D,
		REG_CLOCK_OUTSIDE,
		REG_CLOCK_INSIDE,
		REG_CARRIER_DATA,
		REG_CARRIER_IDLE
	} cfg_reg_t;

	typedef struct packed {
		logic [3:0][3:0][15:0] bit_tone_incs;
		logic [15:0]           clock_inc_outside;
		logic [15:0]           clock_inc_inside;
		logic [15:0]           carrier_inc_data;
		logic [15:0]           carrier_inc_idle;
	} cfg_t;

	// per-sample control traveling alongside the datapath
	typedef struct packed {
		logic valid;
		logic pre;
		logic last;
	} ctl_t;

	typedef logic signed [SINE_W-1:0] sine_t;

endpackage

// ===== src/mfsk_sine.sv =====
// Pipelined polynomial sine of a 16-bit angle, Q15 result.
`timescale 1ns / 1ps

module mfsk_sine import mfsk_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] angle,
	output sine_t       value
);

	logic [14:0] z_s2, z_s3, z_s4, z_s5;
	logic        neg_s2, neg_s3, neg_s4, neg_s5;
	logic [14:0] z2_s3, z2_s4;
	logic [10:0] t_s4;
	logic [13:0] p_s5;
	logic [13:0] inner;
	logic [14:0] r;
	logic [16:0] mag;
	sine_t       value_s6;

	assign inner = SINE_C2 - 14'(t_s4);
	assign r     = SINE_C3 - 15'(p_s5);
	assign mag   = 17'((30'(z_s5) * 30'(r)) >> 13);

	always_ff @(posedge clk) begin
		if (en) begin
			// fold the quadrant down to a magnitude in 0..16384
			z_s2   <= angle[14] ? 15'(SINE_QUARTER - 15'(angle[13:0])) : {1'b0, angle[13:0]};
			neg_s2 <= angle[15];

			z2_s3  <= 15'((30'(z_s2) * 30'(z_s2)) >> 14);
			z_s3   <= z_s2;
			neg_s3 <= neg_s2;

			t_s4   <= 11'((26'(z2_s3) * 26'(SINE_C1)) >> 14);
			z2_s4  <= z2_s3;
			z_s4   <= z_s3;
			neg_s4 <= neg_s3;

			p_s5   <= 14'((29'(z2_s4) * 29'(inner)) >> 14);
			z_s5   <= z_s4;
			neg_s5 <= neg_s4;

			value_s6 <= neg_s5 ? -sine_t'(mag) : sine_t'(mag);
		end
	end

	assign value = value_s6;

endmodule

// ===== src/mfsk_seq.sv =====
// Symbol sequencer: sample counter, clock window and the ten phase accumulators.
`timescale 1ns / 1ps

module mfsk_seq import mfsk_pkg::*; #(
	parameter int SAMPLES_PER_SYMBOL = SAMPLES_PER_SYMBOL_DEF,
	parameter int PHASE_BITS         = PHASE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          preamble,
	input  cfg_t                          cfg,
	output ctl_t                          ctl_s1,
	output logic [NUM_TONES-1:0][15:0]    angle
);

	localparam int IDX_W = $clog2(SAMPLES_PER_SYMBOL);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_SYMBOL - 1);
	// clock window is 0.42 < p/S < 0.92, strict on both ends
	localparam int WIN_LO = (42 * SAMPLES_PER_SYMBOL) / 100;
	localparam int WIN_HI = (92 * SAMPLES_PER_SYMBOL - 1) / 100;

	typedef logic [PHASE_BITS-1:0] phase_t;

	logic                     active_q;
	logic [IDX_W-1:0]         idx_q;
	logic [7:0]               byte_q;
	logic                     pre_q;
	phase_t                   clk_phase_q;
	phase_t                   car_phase_q;
	phase_t [7:0]             bit_phase_q;
	phase_t [NUM_TONES-1:0]   tone_phase;

	logic                     issue;
	logic                     accept;
	logic                     at_last;
	logic                     in_window;
	phase_t                   clk_inc;
	phase_t                   car_inc;
	phase_t [7:0]             bit_inc;

	assign at_last   = (idx_q == LAST_IDX);
	assign issue     = en && active_q;
	assign in_ready  = en && (!active_q || at_last);
	assign accept    = in_valid && in_ready;
	assign in_window = (idx_q > IDX_W'(WIN_LO)) && (idx_q <= IDX_W'(WIN_HI));

	always_comb begin
		clk_inc = phase_t'(in_window ? cfg.clock_inc_inside : cfg.clock_inc_outside);
		car_inc = phase_t'(pre_q ? cfg.carrier_inc_idle : cfg.carrier_inc_data);
		// bit i picks entry 2i+b: register i/2, lane 2*(i&1)+b
		for (int i = 0; i < 8; i++) begin
			bit_inc[i] = phase_t'(cfg.bit_tone_incs[i >> 1][{i[0], byte_q[i]}]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			clk_phase_q <= '0;
			car_phase_q <= '0;
			bit_phase_q <= '0;
			ctl_s1      <= '0;
		end else begin
			if (issue) begin
				clk_phase_q <= clk_phase_q + clk_inc;
				car_phase_q <= car_phase_q + car_inc;
				if (!pre_q) begin
					for (int i = 0; i < 8; i++) begin
						bit_phase_q[i] <= bit_phase_q[i] + bit_inc[i];
					end
				end
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			end
			if (accept) begin
				active_q <= 1'b1;
			end else if (issue && at_last) begin
				active_q <= 1'b0;
			end
			if (en) begin
				ctl_s1 <= '{valid: issue, pre: pre_q, last: at_last};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= data_byte;
			pre_q  <= preamble;
		end
	end

	assign tone_phase = {bit_phase_q, car_phase_q, clk_phase_q};

	// top 16 bits of each phase form the sine angle; a narrower phase is padded with zeros below
	for (genvar g = 0; g < NUM_TONES; g++) begin : g_angle
		if (PHASE_BITS >= 16) begin : g_wide
			assign angle[g] = tone_phase[g][PHASE_BITS-1 -: 16];
		end else begin : g_narrow
			assign angle[g] = {tone_phase[g], (16 - PHASE_BITS)'(0)};
		end
	end

	a_accept_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> active_q && idx_q == '0)
		else $error("symbol did not restart at sample zero after accept");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		issue && at_last |=> idx_q == '0)
		else $error("sample counter did not wrap after last sample");

	a_pre_bits_hold: assert property (@(posedge clk) disable iff (!arst_n)
		issue && pre_q |=> $stable(bit_phase_q))
		else $error("bit tone phases moved during a preamble symbol");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> idx_q == '0)
		else $error("sample counter nonzero while idle");

endmodule

// ===== src/mfsk_mix.sv =====
// Tone summing, scaling, truncation toward zero and saturation to 16 bits.
`timescale 1ns / 1ps

module mfsk_mix import mfsk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  ctl_t                    ctl_s1,
	input  sine_t [NUM_TONES-1:0]   tone_s6,
	output logic                    out_valid,
	output logic signed [15:0]      sample,
	output logic                    last_sample
);

	ctl_t [SINE_LAT-1:0]         ctl_dly;
	ctl_t                        ctl_s6, ctl_s7, ctl_s8, ctl_s9, ctl_s10;
	logic signed [SUM_W-1:0]     sum_a_s7, sum_b_s7, sum_s8;
	logic signed [PROD_W-1:0]    prod_s9;
	logic signed [15:0]          sample_s10;

	logic signed [SUM_W-1:0]     term [NUM_TONES];
	logic signed [13:0]          scale;
	logic signed [PROD_W-1:0]    biased;
	logic signed [20:0]          shifted;
	logic signed [15:0]          sat;

	assign ctl_s6 = ctl_dly[SINE_LAT-1];

	always_comb begin
		for (int i = 0; i < NUM_TONES; i++) begin
			// bit tones drop out of a preamble symbol
			if (i >= TONE_BIT0 && ctl_s6.pre) begin
				term[i] = '0;
			end else begin
				term[i] = SUM_W'(tone_s6[i]);
			end
		end
	end

	assign scale = ctl_s8.pre ? SCALE_PRE : SCALE_DATA;

	// add 2^15-1 on negatives so the arithmetic shift truncates toward zero
	assign biased  = prod_s9 + ((prod_s9 < 0) ? ROUND_BIAS : '0);
	assign shifted = 21'(biased >>> 15);

	always_comb begin
		priority if (shifted > SAT_MAX) begin
			sat = 16'sh7FFF;
		end else if (shifted < SAT_MIN) begin
			sat = 16'sh8000;
		end else begin
			sat = 16'(shifted);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_dly <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
		end else if (en) begin
			ctl_dly <= {ctl_dly[SINE_LAT-2:0], ctl_s1};
			ctl_s7  <= ctl_s6;
			ctl_s8  <= ctl_s7;
			ctl_s9  <= ctl_s8;
			ctl_s10 <= ctl_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_a_s7   <= term[0] + term[1] + term[2] + term[3] + term[4];
			sum_b_s7   <= term[5] + term[6] + term[7] + term[8] + term[9];
			sum_s8     <= sum_a_s7 + sum_b_s7;
			prod_s9    <= PROD_W'(sum_s8) * PROD_W'(scale);
			sample_s10 <= sat;
		end
	end

	assign out_valid   = ctl_s10.valid;
	assign last_sample = ctl_s10.last;
	assign sample      = sample_s10;

endmodule

// ===== src/multitone_fsk_byte_modulator.sv =====
// Top level of the multitone FSK byte modulator: config registers and datapath.
// Each sample runs through the phase registers, the sine pipeline and the mixer stages.
// Throughput: SAMPLES_PER_SYMBOL samples per word, one sample per cycle when not stalled,
// paced by the sequencer; the next word is taken on the cycle the last sample issues.
// A stall on the output freezes the whole pipeline and the sequencer.
// Reset clears config registers, all tone phases and the pipeline valid bits.
`timescale 1ns / 1ps

module multitone_fsk_byte_modulator import mfsk_pkg::*; #(
	parameter int SAMPLES_PER_SYMBOL = SAMPLES_PER_SYMBOL_DEF,
	parameter int PHASE_BITS         = PHASE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               preamble,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               last_sample,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_addr,
	input  logic [63:0]        cfg_wdata
);

	cfg_t                        cfg_q;
	ctl_t                        ctl_s1;
	logic                        en;
	logic [NUM_TONES-1:0][15:0]  angle;
	sine_t [NUM_TONES-1:0]       tone_s6;

	assign en = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_BIT_TONE_A:    cfg_q.bit_tone_incs[0] <= cfg_wdata;
				REG_BIT_TONE_B:    cfg_q.bit_tone_incs[1] <= cfg_wdata;
				REG_BIT_TONE_C:    cfg_q.bit_tone_incs[2] <= cfg_wdata;
				REG_BIT_TONE_D:    cfg_q.bit_tone_incs[3] <= cfg_wdata;
				REG_CLOCK_OUTSIDE: cfg_q.clock_inc_outside <= cfg_wdata[15:0];
				REG_CLOCK_INSIDE:  cfg_q.clock_inc_inside <= cfg_wdata[15:0];
				REG_CARRIER_DATA:  cfg_q.carrier_inc_data <= cfg_wdata[15:0];
				REG_CARRIER_IDLE:  cfg_q.carrier_inc_idle <= cfg_wdata[15:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	mfsk_seq #(
		.SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL),
		.PHASE_BITS         (PHASE_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.preamble  (preamble),
		.cfg       (cfg_q),
		.ctl_s1    (ctl_s1),
		.angle     (angle)
	);

	for (genvar g = 0; g < NUM_TONES; g++) begin : g_tone
		mfsk_sine u_sine (
			.clk   (clk),
			.en    (en),
			.angle (angle[g]),
			.value (tone_s6[g])
		);
	end

	mfsk_mix u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctl_s1      (ctl_s1),
		.tone_s6     (tone_s6),
		.out_valid   (out_valid),
		.sample      (sample),
		.last_sample (last_sample)
	);

endmodule
